[design/multi_level_task_deque_unit_defines.svh]
// Assertion macros for the multi-level task deque unit.
// Included by the checker module; depends on nothing else.
`ifndef MULTI_LEVEL_TASK_DEQUE_UNIT_DEFINES_SVH
`define MULTI_LEVEL_TASK_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MTDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MTDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/mtdq_pkg.sv]
// Shared constants, codes and types of the multi-level task deque unit.
// Used by mtdq_store and multi_level_task_deque_unit.
package mtdq_pkg;

  localparam int LEVELS   = 16;
  localparam int CAPACITY = 256;
  localparam int TAG_BITS = 16;
  localparam int LVL_W    = 4;                    // level field and level index
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int FCNT_W   = SLOT_W + 1;
  localparam int OC_W     = 16;
  localparam logic [OC_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_PUSH     = 2'd0,
    KIND_POP      = 2'd1,
    KIND_STEAL    = 2'd2,
    KIND_COMPLETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_TAKE_RD,
    S_TAKE_WR,
    S_CMPL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                tag_we;
    logic [SLOT_W-1:0]   tag_waddr;
    logic [TAG_BITS-1:0] tag_wdata;
    logic                next_we;
    logic [SLOT_W-1:0]   next_waddr;
    logic [SLOT_W-1:0]   next_wdata;
    logic                prev_we;
    logic [SLOT_W-1:0]   prev_waddr;
    logic [SLOT_W-1:0]   prev_wdata;
    logic                free_rd_en;
    logic [SLOT_W-1:0]   free_rd_addr;
    logic                free_we;
    logic [SLOT_W-1:0]   free_waddr;
    logic [SLOT_W-1:0]   free_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [SLOT_W-1:0]   next;
    logic [SLOT_W-1:0]   prev;
    logic [SLOT_W-1:0]   free_slot;
  } mem_rsp_t;

endpackage

[design/mtdq_store.sv]
// Slot memories (tag, next, prev) and the free-slot stack memory.
// Depends on mtdq_pkg; read data is registered, one write per memory a cycle.
module mtdq_store (
  input  logic              clk,
  input  logic              rst_n,
  input  mtdq_pkg::mem_req_t req,
  output mtdq_pkg::mem_rsp_t rsp
);

  logic [mtdq_pkg::TAG_BITS-1:0] tag_mem  [mtdq_pkg::CAPACITY];
  logic [mtdq_pkg::SLOT_W-1:0]   next_mem [mtdq_pkg::CAPACITY];
  logic [mtdq_pkg::SLOT_W-1:0]   prev_mem [mtdq_pkg::CAPACITY];
  logic [mtdq_pkg::SLOT_W-1:0]   free_mem [mtdq_pkg::CAPACITY];
  logic [mtdq_pkg::CAPACITY-1:0] free_vld_r;

  logic [mtdq_pkg::TAG_BITS-1:0] tag_q_r;
  logic [mtdq_pkg::SLOT_W-1:0]   next_q_r;
  logic [mtdq_pkg::SLOT_W-1:0]   prev_q_r;
  logic [mtdq_pkg::SLOT_W-1:0]   free_q_r;
  logic [mtdq_pkg::SLOT_W-1:0]   free_addr_r;
  logic                          free_hit_r;

  always_ff @(posedge clk) begin
    if (req.tag_we)  tag_mem[req.tag_waddr]   <= req.tag_wdata;
    if (req.next_we) next_mem[req.next_waddr] <= req.next_wdata;
    if (req.prev_we) prev_mem[req.prev_waddr] <= req.prev_wdata;
    if (req.free_we) free_mem[req.free_waddr] <= req.free_wdata;
    if (req.rd_en) begin
      tag_q_r  <= tag_mem[req.rd_addr];
      next_q_r <= next_mem[req.rd_addr];
      prev_q_r <= prev_mem[req.rd_addr];
    end
    if (req.free_rd_en) begin
      free_q_r    <= free_mem[req.free_rd_addr];
      free_addr_r <= req.free_rd_addr;
    end
  end

  // An entry never written holds its own index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r <= '0;
      free_hit_r <= 1'b0;
    end else begin
      if (req.free_we) free_vld_r[req.free_waddr] <= 1'b1;
      if (req.free_rd_en) free_hit_r <= free_vld_r[req.free_rd_addr];
    end
  end

  assign rsp.tag       = tag_q_r;
  assign rsp.next      = next_q_r;
  assign rsp.prev      = prev_q_r;
  assign rsp.free_slot = free_hit_r ? free_q_r : free_addr_r;

endmodule

[design/multi_level_task_deque_unit.sv]
// Channel | Dir | Words                         | Handshake
// in_     | in  | kind in tuser, level+tag data | tvalid/tready
// out_    | out | status, tag, level, above     | tvalid/tready
// Push and pop/steal go from memory read to write-back to result, then to the output
// register; complete goes straight to result, as do a push into a full pool and a pop
// or steal with every list empty. The block returns to idle before the next word is taken.
// The single registered read port of the slot and free-stack memories sets this sequence.
// rst_n is synchronous; no clearing pass is needed.
// A stalled output holds its word; a finished result waits for the register to empty.
// Top level: sequencer, list ends, counts and output register; memories in mtdq_store.
// Depends on mtdq_pkg and mtdq_store.
module multi_level_task_deque_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // level[3:0], task_tag[19:4], zero pad
  input  logic [1:0]  in_tuser,  // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata  // status[1:0], out_tag[17:2], out_level[21:18],
                                 // outstanding_above[22], zero pad
);

  localparam int LW = mtdq_pkg::LVL_W;
  localparam int SW = mtdq_pkg::SLOT_W;
  localparam int TW = mtdq_pkg::TAG_BITS;

  mtdq_pkg::state_t state_r, state_nxt;
  mtdq_pkg::kind_t  kind_r, kind_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [TW-1:0] tag_r, tag_nxt;

  logic [SW-1:0] head_r [mtdq_pkg::LEVELS];
  logic [SW-1:0] tail_r [mtdq_pkg::LEVELS];
  logic [mtdq_pkg::OC_W-1:0] cnt_r [mtdq_pkg::LEVELS];
  logic [mtdq_pkg::LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [mtdq_pkg::LEVELS-1:0] nz_r, nz_nxt;
  logic [mtdq_pkg::FCNT_W-1:0] fc_r, fc_nxt;

  logic [LW-1:0] src_r, src_nxt;
  logic          single_r, single_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;

  mtdq_pkg::status_t st_r, st_nxt;
  logic [TW-1:0] otag_r, otag_nxt;
  logic [LW-1:0] olev_r, olev_nxt;

  logic          ovld_r, ovld_nxt;
  logic [23:0]   odata_r, odata_nxt;

  logic          head_we, tail_we, cnt_we;
  logic [LW-1:0] head_wl, tail_wl;
  logic [SW-1:0] head_wd, tail_wd;
  logic [mtdq_pkg::OC_W-1:0] cnt_wd;

  mtdq_pkg::mem_req_t req;
  mtdq_pkg::mem_rsp_t rsp;

  logic          hi_found, lo_found;
  logic [LW-1:0] hi_lvl, lo_lvl;
  logic [mtdq_pkg::LEVELS-1:0] above_bits;

  mtdq_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Highest and lowest non-empty level.
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_lvl   = '0;
    lo_lvl   = '0;
    for (int i = 0; i < mtdq_pkg::LEVELS; i++) begin
      if (nonempty_r[i]) begin
        hi_found = 1'b1;
        hi_lvl   = LW'(i);
      end
      if (nonempty_r[mtdq_pkg::LEVELS-1-i]) begin
        lo_found = 1'b1;
        lo_lvl   = LW'(mtdq_pkg::LEVELS-1-i);
      end
    end
  end

  assign above_bits = (nz_r >> lv_r) >> 1;
  assign in_tready  = (state_r == mtdq_pkg::S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    lv_nxt       = lv_r;
    tag_nxt      = tag_r;
    nonempty_nxt = nonempty_r;
    nz_nxt       = nz_r;
    fc_nxt       = fc_r;
    src_nxt      = src_r;
    single_nxt   = single_r;
    sidx_nxt     = sidx_r;
    st_nxt       = st_r;
    otag_nxt     = otag_r;
    olev_nxt     = olev_r;
    ovld_nxt     = ovld_r;
    odata_nxt    = odata_r;
    head_we = 1'b0;  head_wl = lv_r;  head_wd = '0;
    tail_we = 1'b0;  tail_wl = lv_r;  tail_wd = '0;
    cnt_we  = 1'b0;  cnt_wd  = cnt_r[lv_r];
    req = '0;

    if (ovld_r && out_tready) ovld_nxt = 1'b0;

    case (state_r)
      mtdq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = mtdq_pkg::kind_t'(in_tuser);
          lv_nxt   = in_tdata[LW-1:0];
          tag_nxt  = in_tdata[LW +: TW];
          st_nxt   = mtdq_pkg::ST_DONE;
          otag_nxt = '0;
          olev_nxt = '0;
          case (mtdq_pkg::kind_t'(in_tuser))
            mtdq_pkg::KIND_PUSH: state_nxt = mtdq_pkg::S_PUSH_RD;
            mtdq_pkg::KIND_POP, mtdq_pkg::KIND_STEAL: state_nxt = mtdq_pkg::S_TAKE_RD;
            default: state_nxt = mtdq_pkg::S_CMPL;
          endcase
        end
      end
      mtdq_pkg::S_PUSH_RD: begin
        if (fc_r == '0) begin
          st_nxt    = mtdq_pkg::ST_FULL;
          state_nxt = mtdq_pkg::S_FIN;
        end else begin
          req.free_rd_en   = 1'b1;
          req.free_rd_addr = SW'(fc_r - 1'b1);
          state_nxt        = mtdq_pkg::S_PUSH_WR;
        end
      end
      mtdq_pkg::S_PUSH_WR: begin
        fc_nxt        = fc_r - 1'b1;
        req.tag_we    = 1'b1;
        req.tag_waddr = rsp.free_slot;
        req.tag_wdata = tag_r;
        if (nonempty_r[lv_r]) begin
          req.next_we    = 1'b1;
          req.next_waddr = tail_r[lv_r];
          req.next_wdata = rsp.free_slot;
          req.prev_we    = 1'b1;
          req.prev_waddr = rsp.free_slot;
          req.prev_wdata = tail_r[lv_r];
        end else begin
          head_we = 1'b1;
          head_wd = rsp.free_slot;
          nonempty_nxt[lv_r] = 1'b1;
        end
        tail_we = 1'b1;
        tail_wd = rsp.free_slot;
        cnt_we  = 1'b1;
        cnt_wd  = (cnt_r[lv_r] == mtdq_pkg::COUNT_MAX) ? cnt_r[lv_r] : cnt_r[lv_r] + 1'b1;
        nz_nxt[lv_r] = 1'b1;
        state_nxt = mtdq_pkg::S_FIN;
      end
      mtdq_pkg::S_TAKE_RD: begin
        if ((kind_r == mtdq_pkg::KIND_POP) ? !hi_found : !lo_found) begin
          st_nxt    = mtdq_pkg::ST_EMPTY;
          state_nxt = mtdq_pkg::S_FIN;
        end else begin
          src_nxt     = (kind_r == mtdq_pkg::KIND_POP) ? hi_lvl : lo_lvl;
          sidx_nxt    = (kind_r == mtdq_pkg::KIND_POP) ? head_r[src_nxt] : tail_r[src_nxt];
          single_nxt  = (head_r[src_nxt] == tail_r[src_nxt]);
          req.rd_en   = 1'b1;
          req.rd_addr = sidx_nxt;
          state_nxt   = mtdq_pkg::S_TAKE_WR;
        end
      end
      mtdq_pkg::S_TAKE_WR: begin
        otag_nxt = rsp.tag;
        olev_nxt = src_r;
        head_wl  = src_r;
        tail_wl  = src_r;
        if (single_r) begin
          nonempty_nxt[src_r] = 1'b0;
        end else if (kind_r == mtdq_pkg::KIND_POP) begin
          head_we = 1'b1;
          head_wd = rsp.next;
        end else begin
          tail_we = 1'b1;
          tail_wd = rsp.prev;
        end
        // Return the slot to the free stack.
        req.free_we    = 1'b1;
        req.free_waddr = SW'(fc_r);
        req.free_wdata = sidx_r;
        fc_nxt    = fc_r + 1'b1;
        state_nxt = mtdq_pkg::S_FIN;
      end
      mtdq_pkg::S_CMPL: begin
        if (cnt_r[lv_r] == '0) begin
          st_nxt = mtdq_pkg::ST_ZERO;
        end else begin
          cnt_we = 1'b1;
          cnt_wd = cnt_r[lv_r] - 1'b1;
          nz_nxt[lv_r] = (cnt_r[lv_r] != mtdq_pkg::OC_W'(1));
        end
        state_nxt = mtdq_pkg::S_FIN;
      end
      mtdq_pkg::S_FIN: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = {1'b0, |above_bits, olev_r, otag_r, st_r};
          state_nxt = mtdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mtdq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mtdq_pkg::S_IDLE;
      nonempty_r <= '0;
      nz_r       <= '0;
      fc_r       <= mtdq_pkg::FCNT_W'(mtdq_pkg::CAPACITY);
      ovld_r     <= 1'b0;
      for (int i = 0; i < mtdq_pkg::LEVELS; i++) cnt_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      nonempty_r <= nonempty_nxt;
      nz_r       <= nz_nxt;
      fc_r       <= fc_nxt;
      ovld_r     <= ovld_nxt;
      if (cnt_we) cnt_r[lv_r] <= cnt_wd;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    lv_r     <= lv_nxt;
    tag_r    <= tag_nxt;
    src_r    <= src_nxt;
    single_r <= single_nxt;
    sidx_r   <= sidx_nxt;
    st_r     <= st_nxt;
    otag_r   <= otag_nxt;
    olev_r   <= olev_nxt;
    odata_r  <= odata_nxt;
    if (head_we) head_r[head_wl] <= head_wd;
    if (tail_we) tail_r[tail_wl] <= tail_wd;
  end

endmodule

[design/mtdq_checker.sv]
// Port-level checker for multi_level_task_deque_unit, bound to the top level.
// Depends on multi_level_task_deque_unit_defines.svh and mtdq_pkg.
`include "multi_level_task_deque_unit_defines.svh"

module mtdq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // A stalled result word holds.
  `MTDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // One word at a time: busy right after taking a word.
  `MTDQ_ASSERT_NEXT(a_busy_after_acc, clk, rst_n, in_acc, !in_tready)
  // Nothing removed means no tag and no level.
  `MTDQ_ASSERT_NOW(a_fail_zero, clk, rst_n, out_tvalid && (out_tdata[1:0] != mtdq_pkg::ST_DONE), out_tdata[21:2] == 20'd0)
  // Pad bit stays clear.
  `MTDQ_ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[23] == 1'b0)

endmodule

bind multi_level_task_deque_unit mtdq_checker u_mtdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/tb.sv]
// Self-checking bench for multi_level_task_deque_unit: directed and random push, pop, steal and
// complete words against a behavioural model of the per-level lists and counts.
// Depends on mtdq_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [3:0]  lvl;
    logic        above;
  } result_t;

  class deque_scoreboard;
    logic [15:0] lists[16][$];
    logic [15:0] counts[16];
    int          used;
    result_t     pending[$];
    int          mismatches;
    int          checked;

    function void clear();
      for (int i = 0; i < 16; i++) begin
        lists[i].delete();
        counts[i] = '0;
      end
      used = 0;
      pending.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    // Apply one accepted word to the model and queue the result it causes.
    function void note_word(mtdq_pkg::kind_t kind, logic [3:0] lv, logic [15:0] tg);
      result_t r;
      int src;
      r = '0;
      src = -1;
      case (kind)
        mtdq_pkg::KIND_PUSH: begin
          if (used == mtdq_pkg::CAPACITY) begin
            r.status = mtdq_pkg::ST_FULL;
          end else begin
            lists[lv].push_back(tg);
            used++;
            if (counts[lv] != mtdq_pkg::COUNT_MAX) counts[lv]++;
          end
        end
        mtdq_pkg::KIND_POP, mtdq_pkg::KIND_STEAL: begin
          if (kind == mtdq_pkg::KIND_POP) begin
            for (int i = 15; i >= 0; i--)
              if (src < 0 && lists[i].size() != 0) src = i;
          end else begin
            for (int i = 0; i < 16; i++)
              if (src < 0 && lists[i].size() != 0) src = i;
          end
          if (src < 0) begin
            r.status = mtdq_pkg::ST_EMPTY;
          end else begin
            r.tag = (kind == mtdq_pkg::KIND_POP) ? lists[src].pop_front() :
                                                   lists[src].pop_back();
            r.lvl = src[3:0];
            used--;
          end
        end
        default: begin
          if (counts[lv] == 0) r.status = mtdq_pkg::ST_ZERO;
          else counts[lv]--;
        end
      endcase
      for (int j = lv + 1; j < 16; j++)
        if (counts[j] != 0) r.above = 1'b1;
      pending.push_back(r);
    endfunction

    function void check_word(logic [23:0] d);
      result_t got, exp_r;
      got.status = d[1:0];
      got.tag = d[17:2];
      got.lvl = d[21:18];
      got.above = d[22];
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", d);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r || d[23] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp status %0d tag %h lvl %0d above %0b, got %0d %h %0d %0b",
                   exp_r.status, exp_r.tag, exp_r.lvl, exp_r.above,
                   got.status, got.tag, got.lvl, got.above);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // level[3:0], task_tag[19:4], zero pad
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // status[1:0], out_tag[17:2], out_level[21:18], above[22]

  deque_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int cycles;
  int sent;

  multi_level_task_deque_unit u_dut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    if (rst_n) out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one word, with random idle cycles before it; hold until taken.
  task automatic send_word(mtdq_pkg::kind_t kind, logic [3:0] lv, logic [15:0] tg);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0, tg, lv};
    do @(posedge clk); while (!in_tready);
    sb.note_word(kind, lv, tg);
    sent++;
  endtask

  task automatic random_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      // Bias towards pushes so lists grow and levels overlap.
      if (r < 40)      send_word(mtdq_pkg::KIND_PUSH, 4'($urandom), 16'($urandom));
      else if (r < 60) send_word(mtdq_pkg::KIND_POP, 4'($urandom), 16'($urandom));
      else if (r < 80) send_word(mtdq_pkg::KIND_STEAL, 4'($urandom), 16'($urandom));
      else             send_word(mtdq_pkg::KIND_COMPLETE, 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = mtdq_pkg::KIND_PUSH;
    out_tready = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, zero counts, field extremes, head and tail removals.
    send_word(mtdq_pkg::KIND_POP, 4'd0, 16'h0000);
    send_word(mtdq_pkg::KIND_STEAL, 4'd15, 16'hffff);
    send_word(mtdq_pkg::KIND_COMPLETE, 4'd0, 16'h0000);
    send_word(mtdq_pkg::KIND_PUSH, 4'd0, 16'h0000);
    send_word(mtdq_pkg::KIND_PUSH, 4'd15, 16'hffff);
    send_word(mtdq_pkg::KIND_PUSH, 4'd15, 16'h5a5a);
    send_word(mtdq_pkg::KIND_PUSH, 4'd15, 16'ha5a5);
    send_word(mtdq_pkg::KIND_COMPLETE, 4'd0, 16'h0);
    send_word(mtdq_pkg::KIND_POP, 4'd0, 16'h0);
    send_word(mtdq_pkg::KIND_STEAL, 4'd7, 16'h0);
    send_word(mtdq_pkg::KIND_STEAL, 4'd7, 16'h0);
    send_word(mtdq_pkg::KIND_POP, 4'd15, 16'h0);
    send_word(mtdq_pkg::KIND_POP, 4'd3, 16'h0);
    send_word(mtdq_pkg::KIND_COMPLETE, 4'd15, 16'h0);
    send_word(mtdq_pkg::KIND_COMPLETE, 4'd15, 16'h0);

    // Fill the pool, overflow it, then drain it.
    for (int i = 0; i < mtdq_pkg::CAPACITY + 3; i++)
      send_word(mtdq_pkg::KIND_PUSH, 4'($urandom), 16'($urandom));
    for (int i = 0; i < mtdq_pkg::CAPACITY + 2; i++)
      send_word(($urandom_range(1)) ? mtdq_pkg::KIND_POP : mtdq_pkg::KIND_STEAL,
                4'($urandom), 16'($urandom));

    idle_pct = 0;  stall_pct = 0;  random_burst(70);
    idle_pct = 80; stall_pct = 0;  random_burst(70);
    idle_pct = 0;  stall_pct = 80; random_burst(70);
    idle_pct = 9;  stall_pct = 9;  random_burst(70);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words, checked %0d results over four idle/stall phases",
             sent, sb.checked);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
